/* rtl/hvd_pkg.sv */
// Shared types, widths and constant tables for the haversine distance pipeline.
package hvd_pkg;

   // Default iteration count of each CORDIC chain
   localparam int CORDIC_STEPS_DEF = 24;

   // Data widths
   localparam int DW  = 34;          // CORDIC datapath, signed Q30 with headroom
   localparam int HW  = 34;          // angle in half-units of 1e-7 degree
   localparam int PW  = 2 * DW;      // full product of two datapath words
   localparam int SW  = 62;          // square-root remainder and root
   localparam int SQRT_STEPS = 31;   // one root bit per cell, from bit 60 down

   // Angle constants, in units of 5e-8 degree
   localparam logic signed [HW-1:0] FULL_TURN_H    = 34'sd7200000000;
   localparam logic signed [HW-1:0] HALF_TURN_H    = 34'sd3600000000;
   localparam logic signed [HW-1:0] QUARTER_TURN_H = 34'sd1800000000;

   // Conversion of half-units to Q30 radians, as a Q62 factor
   localparam logic [31:0] HALFUNIT_TO_RAD_Q62 = 32'd4024455254;

   // Start gain of rotation mode, 0.60725293 in Q30
   localparam logic signed [DW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [60:0] ONE_Q60      = 61'd1 << 60;
   localparam logic [23:0] TWO_RADIUS_M = 24'd12742000;
   localparam logic [24:0] DIST_MAX     = 25'd20015087;

   // atan(2^-i) in Q30, rounded to nearest
   localparam logic [31:0] ATAN_TABLE [0:31] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768,
      32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128,
      32'd64,        32'd32,        32'd16,        32'd8,
      32'd4,         32'd2,         32'd1,         32'd1
   };

   // One CORDIC vector travelling down a chain
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] z;
      logic                 neg_cos;
   } cordic_type;

   // One square-root lane: remainder and partial root
   typedef struct packed {
      logic [SW-1:0] rem;
      logic [SW-1:0] root;
   } sqrt_type;

endpackage

/* rtl/hvd_rot_cell.sv */
// One rotation-mode CORDIC iteration with its output register.
module hvd_rot_cell import hvd_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type prev,
   output cordic_type cur_ff
);

   localparam logic signed [DW-1:0] AT = DW'(ATAN_TABLE[IDX]);

   cordic_type cur_in;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;

   // Rotate towards zero residual angle
   always_comb begin
      dx = prev.y >>> IDX;
      dy = prev.x >>> IDX;
      cur_in.neg_cos = prev.neg_cos;
      if (prev.z >= 0) begin
         cur_in.x = prev.x - dx;
         cur_in.y = prev.y + dy;
         cur_in.z = prev.z - AT;
      end else begin
         cur_in.x = prev.x + dx;
         cur_in.y = prev.y - dy;
         cur_in.z = prev.z + AT;
      end
   end

   // Advance
   always_ff @(posedge clock) begin
      if (en) begin
         cur_ff <= cur_in;
      end
   end

endmodule

/* rtl/hvd_sqrt_cell.sv */
// One shift-subtract square-root step with its output register.
module hvd_sqrt_cell import hvd_pkg::*; #(
   parameter int POS = 0
) (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type prev,
   output sqrt_type cur_ff
);

   localparam logic [SW-1:0] BIT = SW'(1) << (60 - 2 * POS);

   sqrt_type cur_in;
   logic [SW-1:0] trial;

   // Take the bit where the remainder allows
   always_comb begin
      trial = prev.root + BIT;
      if (prev.rem >= trial) begin
         cur_in.rem  = prev.rem - trial;
         cur_in.root = (prev.root >> 1) + BIT;
      end else begin
         cur_in.rem  = prev.rem;
         cur_in.root = prev.root >> 1;
      end
   end

   // Advance
   always_ff @(posedge clock) begin
      if (en) begin
         cur_ff <= cur_in;
      end
   end

endmodule

/* rtl/hvd_vec_cell.sv */
// One vectoring-mode CORDIC iteration with its output register.
module hvd_vec_cell import hvd_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type prev,
   output cordic_type cur_ff
);

   localparam logic signed [DW-1:0] AT = DW'(ATAN_TABLE[IDX]);

   cordic_type cur_in;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;

   // Rotate the vector towards the x axis, accumulate the angle
   always_comb begin
      dx = prev.y >>> IDX;
      dy = prev.x >>> IDX;
      cur_in.neg_cos = prev.neg_cos;
      if (prev.y >= 0) begin
         cur_in.x = prev.x + dx;
         cur_in.y = prev.y - dy;
         cur_in.z = prev.z + AT;
      end else begin
         cur_in.x = prev.x - dx;
         cur_in.y = prev.y + dy;
         cur_in.z = prev.z - AT;
      end
   end

   // Advance
   always_ff @(posedge clock) begin
      if (en) begin
         cur_ff <= cur_in;
      end
   end

endmodule

/* rtl/haversine_distance.sv */
// Great-circle distance between two positions, haversine formula, fully pipelined.
//
// Usage: present two positions (1e-7 degree units) on req_* with req_valid;
// an item is taken at a clock edge where req_valid is high and req_stall low.
// The distance in whole metres appears on rsp_distance_m with rsp_valid and
// is taken where rsp_valid is high and rsp_stall low.
// Throughput: one item per cycle while rsp_stall does not hold the pipeline.
// The registered stages, in order: angle preparation, four angle lanes of
// rotation CORDIC, multiply stages, two lanes of 31 square-root cells, a
// vectoring CORDIC chain and the scaling and saturation stages.
// The whole pipeline advances together; while a result waits under
// rsp_stall every stage holds and req_stall is raised.
// Reset (synchronous, active high) clears all valid flags; payload
// registers are left as they are. No configuration is needed.
module haversine_distance import hvd_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_lat_a,
   input  logic signed [31:0] req_lon_a,
   input  logic signed [30:0] req_lat_b,
   input  logic signed [31:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [24:0]        rsp_distance_m
);

   localparam int NSTG = 40 + 2 * CORDIC_STEPS;

   logic en;
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic            rsp_valid_ff;

   // Global advance: hold everything while a result waits
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   assign valid_in = {valid_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[NSTG-1];
      end
   end

   // Angle lanes: half dlat, half dlon, lat_a, lat_b (5e-8 degree units)
   logic signed [HW-1:0] h_ff [0:3];
   logic signed [HW-1:0] h_in [0:3];
   logic signed [HW-1:0] r_ff [0:3];
   logic signed [HW-1:0] r_in [0:3];
   logic [30:0]          mag_ff [0:3];
   logic [30:0]          mag_in [0:3];
   logic                 nang_ff [0:3];
   logic                 nang_in [0:3];
   logic                 ncos_ff [0:3];
   logic                 ncos_in [0:3];
   logic signed [DW-1:0] z_ff [0:3];
   logic signed [DW-1:0] z_in [0:3];
   logic                 zc_ff [0:3];

   always_comb begin
      h_in[0] = HW'(req_lat_b) - HW'(req_lat_a);
      h_in[1] = HW'(req_lon_b) - HW'(req_lon_a);
      h_in[2] = HW'(req_lat_a) <<< 1;
      h_in[3] = HW'(req_lat_b) <<< 1;
   end

   for (genvar ln = 0; ln < 4; ln++) begin : g_lane
      logic signed [HW-1:0] fold;
      logic [62:0]          prod;

      // Wrap into one turn around zero
      always_comb begin
         if (h_ff[ln] >= HALF_TURN_H) begin
            r_in[ln] = h_ff[ln] - FULL_TURN_H;
         end else if (h_ff[ln] < -HALF_TURN_H) begin
            r_in[ln] = h_ff[ln] + FULL_TURN_H;
         end else begin
            r_in[ln] = h_ff[ln];
         end
      end

      // Fold into a quarter turn, take magnitude
      always_comb begin
         fold        = r_ff[ln];
         ncos_in[ln] = 1'b0;
         if (r_ff[ln] > QUARTER_TURN_H) begin
            fold        = HALF_TURN_H - r_ff[ln];
            ncos_in[ln] = 1'b1;
         end else if (r_ff[ln] < -QUARTER_TURN_H) begin
            fold        = -HALF_TURN_H - r_ff[ln];
            ncos_in[ln] = 1'b1;
         end
         nang_in[ln] = fold < 0;
         mag_in[ln]  = nang_in[ln] ? 31'(-fold) : 31'(fold);
      end

      // Convert to Q30 radians, rounded
      always_comb begin
         prod = 63'(mag_ff[ln]) * 63'(HALFUNIT_TO_RAD_Q62) + (63'd1 << 31);
         z_in[ln] = nang_ff[ln] ? -DW'(prod[62:32]) : DW'(prod[62:32]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            h_ff[ln]    <= h_in[ln];
            r_ff[ln]    <= r_in[ln];
            mag_ff[ln]  <= mag_in[ln];
            nang_ff[ln] <= nang_in[ln];
            ncos_ff[ln] <= ncos_in[ln];
            z_ff[ln]    <= z_in[ln];
            zc_ff[ln]   <= ncos_ff[ln];
         end
      end
   end

   // Rotation chains, one per angle lane
   cordic_type rot [0:CORDIC_STEPS][0:3];

   for (genvar ln = 0; ln < 4; ln++) begin : g_rot_lane
      assign rot[0][ln] = '{x: CORDIC_GAIN_Q30, y: '0, z: z_ff[ln], neg_cos: zc_ff[ln]};
      for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
         hvd_rot_cell #(.IDX(k)) u_cell (
            .clock  (clock),
            .en     (en),
            .prev   (rot[k][ln]),
            .cur_ff (rot[k+1][ln])
         );
      end
   end

   // Build a = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2)
   logic signed [DW-1:0] s1, s2, ca, cb;
   logic signed [PW-1:0] m1_t1_ff, m1_cc_ff, m2_t1_ff, m2_u_ff, m3_t1_ff, m3_t2_ff;
   logic signed [DW-1:0] m1_s2_ff, m2_s2_ff;
   logic signed [DW-1:0] cc, uq;
   logic signed [PW:0]   a_sum;
   logic [60:0]          a_in;
   logic [60:0]          a_ff;

   always_comb begin
      s1 = rot[CORDIC_STEPS][0].y;
      s2 = rot[CORDIC_STEPS][1].y;
      ca = rot[CORDIC_STEPS][2].neg_cos ? -rot[CORDIC_STEPS][2].x : rot[CORDIC_STEPS][2].x;
      cb = rot[CORDIC_STEPS][3].neg_cos ? -rot[CORDIC_STEPS][3].x : rot[CORDIC_STEPS][3].x;
      cc = DW'(m1_cc_ff >>> 30);
      uq = DW'(m2_u_ff >>> 30);
      a_sum = (PW+1)'(m3_t1_ff) + (PW+1)'(m3_t2_ff);
      if (a_sum < 0) begin
         a_in = '0;
      end else if (a_sum > (PW+1)'(ONE_Q60)) begin
         a_in = ONE_Q60;
      end else begin
         a_in = a_sum[60:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_t1_ff <= s1 * s1;
         m1_cc_ff <= ca * cb;
         m1_s2_ff <= s2;
         m2_t1_ff <= m1_t1_ff;
         m2_u_ff  <= cc * m1_s2_ff;
         m2_s2_ff <= m1_s2_ff;
         m3_t1_ff <= m2_t1_ff;
         m3_t2_ff <= uq * m2_s2_ff;
         a_ff     <= a_in;
      end
   end

   // Square roots of a and 1 - a, one root bit per cell
   sqrt_type sq [0:SQRT_STEPS][0:1];

   assign sq[0][0] = '{rem: SW'(a_ff), root: '0};
   assign sq[0][1] = '{rem: SW'(ONE_Q60 - a_ff), root: '0};

   for (genvar ln = 0; ln < 2; ln++) begin : g_sq_lane
      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
         hvd_sqrt_cell #(.POS(k)) u_cell (
            .clock  (clock),
            .en     (en),
            .prev   (sq[k][ln]),
            .cur_ff (sq[k+1][ln])
         );
      end
   end

   // atan2(sqrt(a), sqrt(1 - a)) by vectoring
   cordic_type vec [0:CORDIC_STEPS];

   assign vec[0] = '{x: DW'(sq[SQRT_STEPS][1].root), y: DW'(sq[SQRT_STEPS][0].root),
                     z: '0, neg_cos: 1'b0};

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
      hvd_vec_cell #(.IDX(k)) u_cell (
         .clock  (clock),
         .en     (en),
         .prev   (vec[k]),
         .cur_ff (vec[k+1])
      );
   end

   // Scale by the diameter, round, saturate
   logic [30:0] zpos;
   logic [55:0] dprod;
   logic [24:0] d_in;
   logic [24:0] d_ff;
   logic [24:0] dist_in;
   logic [24:0] dist_ff;

   always_comb begin
      zpos    = (vec[CORDIC_STEPS].z < 0) ? '0 : vec[CORDIC_STEPS].z[30:0];
      dprod   = 56'(TWO_RADIUS_M) * 56'(zpos) + (56'd1 << 29);
      d_in    = dprod[54:30];
      dist_in = (d_ff > DIST_MAX) ? DIST_MAX : d_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance_m = dist_ff;

endmodule

/* tb/sv/tb_haversine_distance.sv */
// Self-checking testbench for the pipelined haversine distance block.
`timescale 1ns / 100ps

module tb_haversine_distance;
   import hvd_pkg::*;

   localparam int STEPS       = 24;
   localparam int LATENCY     = 40 + 2 * STEPS;
   localparam int CYCLE_LIMIT = 200000;

   localparam longint LAT_MIN = -900000000;
   localparam longint LAT_MAX = 900000000;
   localparam longint LON_MIN = -1800000000;
   localparam longint LON_MAX = 1800000000;

   localparam longint    TURN_H     = 64'sd7200000000;
   localparam longint    HALF_H     = 64'sd3600000000;
   localparam longint    QUARTER_H  = 64'sd1800000000;
   localparam bit [63:0] H_TO_RAD   = 64'd4024455254;
   localparam bit [63:0] PI_4_Q62   = 64'd3622009729038561421;
   localparam longint    START_GAIN = 652032874;
   localparam bit [63:0] UNIT_Q60   = 64'd1 << 60;
   localparam longint    DIAMETER_M = 12742000;
   localparam longint    FAR_LIMIT  = 20015087;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [30:0] req_lat_a = '0;
   logic signed [31:0] req_lon_a = '0;
   logic signed [30:0] req_lat_b = '0;
   logic signed [31:0] req_lon_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [24:0]        rsp_distance_m;

   logic [24:0] expected_dist[$];
   longint      atan_q30_tab[32];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   haversine_distance #(.CORDIC_STEPS(STEPS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_lat_a(req_lat_a), .req_lon_a(req_lon_a),
      .req_lat_b(req_lat_b), .req_lon_b(req_lon_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance_m(rsp_distance_m)
   );

   always #5 clock = ~clock;

   // atan(2^-i) in Q30, from pi/4 for i = 0 and from its power series otherwise, rounded
   function automatic longint arctan_entry(input int i);
      bit [63:0] acc;
      longint    sum;
      int        k, e;
      if (i == 0) begin
         acc = PI_4_Q62;
      end else begin
         sum = 0;
         for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            e = i * (2 * k + 1);
            if (k % 2 == 1) sum -= longint'((64'd1 << (62 - e)) / (2 * k + 1));
            else sum += longint'((64'd1 << (62 - e)) / (2 * k + 1));
         end
         acc = sum;
      end
      return longint'((acc + (64'd1 << 31)) >> 32);
   endfunction

   // Sine and cosine in Q30 of an angle in half-units of 1e-7 degree
   function automatic void sine_cosine(input longint h, output longint s, output longint c);
      longint    r, z, x, y, dx, dy;
      bit        flip_cos, neg_ang;
      bit [63:0] mag;
      r = h % TURN_H;
      flip_cos = 1'b0;
      if (r >= HALF_H) r -= TURN_H;
      if (r < -HALF_H) r += TURN_H;
      if (r > QUARTER_H) begin
         r = HALF_H - r;
         flip_cos = 1'b1;
      end else if (r < -QUARTER_H) begin
         r = -HALF_H - r;
         flip_cos = 1'b1;
      end
      neg_ang = r < 0;
      mag = neg_ang ? -r : r;
      z = longint'((mag * H_TO_RAD + (64'd1 << 31)) >> 32);
      if (neg_ang) z = -z;
      x = START_GAIN;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q30_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_q30_tab[i];
         end
      end
      s = y;
      c = flip_cos ? -x : x;
   endfunction

   // Floor square root of a Q60 value, giving Q30
   function automatic longint root_q60(input bit [63:0] v);
      bit [63:0] res, bitv;
      res = 0;
      bitv = UNIT_Q60;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic logic [24:0] predict_distance(input longint la, input longint oa,
                                                    input longint lb, input longint ob);
      longint s_lat, s_lon, c_a, c_b, unused, cc, u, hav, x, y, z, dx, dy, d;
      sine_cosine(lb - la, s_lat, unused);
      sine_cosine(ob - oa, s_lon, unused);
      sine_cosine(2 * la, unused, c_a);
      sine_cosine(2 * lb, unused, c_b);
      cc = (c_a * c_b) >>> 30;
      u = (cc * s_lon) >>> 30;
      hav = s_lat * s_lat + u * s_lon;
      // clamp a to [0, 1]
      if (hav < 0) hav = 0;
      if (hav > longint'(UNIT_Q60)) hav = longint'(UNIT_Q60);
      y = root_q60(hav);
      x = root_q60(UNIT_Q60 - hav);
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_q30_tab[i];
         end else begin
            x -= dx; y += dy; z -= atan_q30_tab[i];
         end
      end
      if (z < 0) z = 0;
      d = (DIAMETER_M * z + (64'sd1 <<< 29)) >>> 30;
      if (d > FAR_LIMIT) d = FAR_LIMIT;
      return d[24:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Offer one item, idling at random first; hold it until taken
   task automatic send_position_pair(input longint la, input longint oa,
                                     input longint lb, input longint ob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lat_a <= la[30:0];
      req_lon_a <= oa[31:0];
      req_lat_b <= lb[30:0];
      req_lon_b <= ob[31:0];
      do @(posedge clock); while (req_stall);
      expected_dist.push_back(predict_distance(longint'(signed'(la[30:0])),
                                               longint'(signed'(oa[31:0])),
                                               longint'(signed'(lb[30:0])),
                                               longint'(signed'(ob[31:0]))));
   endtask

   task automatic hold_idle();
      req_valid <= 1'b0;
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare each taken result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dist.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_distance_m));
         end else if (rsp_distance_m !== expected_dist[0]) begin
            report_mismatch($sformatf("distance_m got %0d want %0d",
                                      rsp_distance_m, expected_dist[0]));
            void'(expected_dist.pop_front());
         end else begin
            void'(expected_dist.pop_front());
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_directed();
      send_position_pair(0, 0, 0, 0);
      send_position_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
      send_position_pair(LAT_MAX, 0, LAT_MIN, 0);
      send_position_pair(0, 0, 0, LON_MAX);
      send_position_pair(0, LON_MIN, 0, LON_MAX);
      send_position_pair(0, LON_MIN + 1, 0, LON_MAX - 1);
      send_position_pair(LAT_MIN, LON_MIN, LAT_MAX, LON_MAX);
      send_position_pair(0, 0, 1, 0);
      send_position_pair(0, 0, 0, 1);
      send_position_pair(514000000, -1000000, 407000000, -740000000);
      // out-of-range latitude, raw field extremes
      send_position_pair(-(64'sd1 <<< 30), 0, (64'sd1 <<< 30) - 1, 0);
      send_position_pair((64'sd1 <<< 30) - 1, 0, 0, 0);
      // out-of-range longitude, raw field extremes
      send_position_pair(0, -(64'sd1 <<< 31), 0, (64'sd1 <<< 31) - 1);
      send_position_pair(0, 0, 0, -(64'sd1 <<< 31));
      // near-antipodal points drive a past one; saturation at the far end
      send_position_pair(0, 0, 0, LON_MAX - 3);
      send_position_pair(1, 0, -1, LON_MAX);
      send_position_pair(LAT_MAX - 5, 123, LAT_MIN + 5, LON_MIN + 123);
      // polar latitudes make the cosine product vanish
      send_position_pair(LAT_MAX, LON_MIN, LAT_MAX, LON_MAX);
      send_position_pair(LAT_MIN, 17, LAT_MIN, -17);
      hold_idle();
   endtask

   // Mostly valid coordinates, some close pairs and some raw field noise
   task automatic test_random_positions(input int count);
      longint la, oa, lb, ob;
      int     kind;
      repeat (count) begin
         kind = $urandom_range(99);
         la = longint'($urandom_range(1800000000)) - 900000000;
         oa = longint'($urandom_range(2000000000)) * 9 / 5 - 1800000000;
         if (kind < 60) begin
            lb = longint'($urandom_range(1800000000)) - 900000000;
            ob = longint'($urandom_range(2000000000)) * 9 / 5 - 1800000000;
         end else if (kind < 80) begin
            lb = la + longint'($urandom_range(20000)) - 10000;
            ob = oa + longint'($urandom_range(20000)) - 10000;
            if (lb > LAT_MAX || lb < LAT_MIN) lb = la;
            if (ob > LON_MAX || ob < LON_MIN) ob = oa;
         end else begin
            la = longint'(signed'($urandom()));
            oa = longint'(signed'($urandom()));
            lb = longint'(signed'($urandom()));
            ob = longint'(signed'($urandom()));
         end
         send_position_pair(la, oa, lb, ob);
      end
      hold_idle();
   endtask

   // Hold the sender until the pipeline has drained
   task automatic test_drain_pause();
      send_position_pair(100, 200, 300, 400);
      hold_idle();
      wait (expected_dist.size() == 0);
      @(posedge clock);
      send_position_pair(-100, -200, 300, 400);
      hold_idle();
   endtask

   initial begin
      for (int i = 0; i < 32; i++) atan_q30_tab[i] = arctan_entry(i);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 16;
      recv_stall_pct = 47;
      test_directed();
      test_random_positions(630);
      test_drain_pause();

      send_idle_pct = 47;
      recv_stall_pct = 16;
      test_random_positions(630);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_positions(630);

      wait (expected_dist.size() == 0);
      repeat (LATENCY + 32) @(posedge clock);
      if (error_count == 0 && expected_dist.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
